// ----- hdl/plfm_pkg.sv -----
// shared types and constants for the price level matcher
package plfm_pkg;
   localparam int SLOTS_DEF = 32;
   localparam int MAX_TRADES = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_CANCEL = 2'd1,
      OP_MATCH  = 2'd2,
      OP_OTHER  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      K_INSERTED  = 3'd0,
      K_CANCELLED = 3'd1,
      K_TRADE     = 3'd2,
      K_NOFILL    = 3'd3,
      K_FULL      = 3'd4,
      K_BADSLOT   = 3'd5
   } kind_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] order_id;
      logic [31:0] order_qty;
      logic [31:0] order_price;
      logic [4:0]  cancel_slot;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_WAIT,
      ST_LINK,
      ST_FILL,
      ST_OUT
   } state_type;
endpackage

// ----- hdl/plfm_ram.sv -----
// generic single write, single read ram with registered read
module plfm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hdl/plfm_front.sv -----
// front end: accepts items into a two entry queue
module plfm_front import plfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    q_valid,
   input  logic    q_take,
   output cmd_type q_cmd
);
   cmd_type q_ff [2];
   logic    rp_ff, wp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_stall = (cnt_ff == 2'd2);
   assign push = in_valid && !in_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_take;
   assign q_cmd = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= in_cmd;
      end
      if (reset) begin
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef NO_ASSERTIONS
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> in_stall) else $error("full queue not stalled");
`endif
endmodule

// ----- hdl/plfm_back.sv -----
// back end: slot store, linked list and match sequencer
module plfm_back import plfm_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_take,
   input  cmd_type     q_cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [4:0]  rsp_slot,
   output logic [31:0] rsp_maker_id,
   output logic [31:0] rsp_taker_id,
   output logic [31:0] rsp_fill_qty,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_taker_left,
   output logic [5:0]  rsp_orders_resting,
   output logic        rsp_last
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);
   localparam logic [PW-1:0] NONE = PW'(SLOTS);

   state_type state_ff, state_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   cmd_type cmd_ff, cmd_in;
   logic [31:0] left_ff, left_in;
   logic [5:0]  ntr_ff, ntr_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [PW-1:0] prv_ff, prv_in;

   logic o_valid_ff, o_valid_in;
   logic [2:0] o_kind_ff, o_kind_in;
   logic [4:0] o_slot_ff, o_slot_in;
   logic [31:0] o_mk_ff, o_mk_in, o_tk_ff, o_tk_in, o_fq_ff, o_fq_in;
   logic [31:0] o_pr_ff, o_pr_in, o_lf_ff, o_lf_in;
   logic [5:0] o_cnt_ff, o_cnt_in;
   logic o_last_ff, o_last_in;

   // rams: id, qty, price, prev, next
   logic id_we, qty_we, pr_we, pv_we, nx_we;
   logic [AW-1:0] id_wa, qty_wa, pv_wa, nx_wa, rd_a;
   logic [31:0] id_wd, qty_wd, pr_wd, id_rd, qty_rd, pr_rd;
   logic [PW-1:0] pv_wd, nx_wd, pv_rd, nx_rd;

   plfm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_id (.clock(clock), .wr_en(id_we),
      .wr_addr(id_wa), .wr_data(id_wd), .rd_addr(rd_a), .rd_data(id_rd));
   plfm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_qty (.clock(clock), .wr_en(qty_we),
      .wr_addr(qty_wa), .wr_data(qty_wd), .rd_addr(rd_a), .rd_data(qty_rd));
   plfm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_pr (.clock(clock), .wr_en(pr_we),
      .wr_addr(id_wa), .wr_data(pr_wd), .rd_addr(rd_a), .rd_data(pr_rd));
   plfm_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pv (.clock(clock), .wr_en(pv_we),
      .wr_addr(pv_wa), .wr_data(pv_wd), .rd_addr(rd_a), .rd_data(pv_rd));
   plfm_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_nx (.clock(clock), .wr_en(nx_we),
      .wr_addr(nx_wa), .wr_data(nx_wd), .rd_addr(rd_a), .rd_data(nx_rd));

   // lowest free slot
   logic free_any;
   logic [AW-1:0] free_s;
   always_comb begin
      free_any = 1'b0;
      free_s = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_s = AW'(i);
         end
      end
   end

   logic out_free;
   logic [31:0] fill;
   logic [31:0] mq_left;
   assign out_free = !o_valid_ff || !rsp_stall;
   assign fill = (left_ff < qty_rd) ? left_ff : qty_rd;
   assign mq_left = qty_rd - fill;
   logic cs_ok;
   assign cs_ok = (32'(q_cmd.cancel_slot) < 32'(SLOTS)) &&
                  used_ff[q_cmd.cancel_slot[AW-1:0]];

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      left_in = left_ff;
      ntr_in = ntr_ff;
      cur_in = cur_ff;
      prv_in = prv_ff;
      q_take = 1'b0;
      rd_a = cur_ff;
      id_we = 1'b0; qty_we = 1'b0; pr_we = 1'b0; pv_we = 1'b0; nx_we = 1'b0;
      id_wa = cur_ff; qty_wa = cur_ff; pv_wa = cur_ff; nx_wa = cur_ff;
      id_wd = cmd_ff.order_id; qty_wd = cmd_ff.order_qty;
      pr_wd = cmd_ff.order_price;
      pv_wd = tail_ff; nx_wd = NONE;
      o_valid_in = o_valid_ff && rsp_stall;
      o_kind_in = o_kind_ff; o_slot_in = o_slot_ff; o_mk_in = o_mk_ff;
      o_tk_in = o_tk_ff; o_fq_in = o_fq_ff; o_pr_in = o_pr_ff;
      o_lf_in = o_lf_ff; o_cnt_in = o_cnt_ff; o_last_in = o_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_take = 1'b1;
               cmd_in = q_cmd;
               left_in = q_cmd.order_qty;
               ntr_in = '0;
               o_kind_in = K_INSERTED; o_slot_in = '0; o_mk_in = '0;
               o_tk_in = '0; o_fq_in = '0; o_pr_in = '0; o_lf_in = '0;
               o_last_in = 1'b1;
               case (q_cmd.op)
                  OP_INSERT: begin
                     if (!free_any) begin
                        o_valid_in = 1'b1;
                        o_kind_in = K_FULL;
                        o_cnt_in = 6'(cnt_ff);
                     end else begin
                        cur_in = free_s;
                        state_in = ST_LINK;
                     end
                  end
                  OP_CANCEL: begin
                     o_slot_in = q_cmd.cancel_slot;
                     if (!cs_ok) begin
                        o_valid_in = 1'b1;
                        o_kind_in = K_BADSLOT;
                        o_cnt_in = 6'(cnt_ff);
                     end else begin
                        cur_in = q_cmd.cancel_slot[AW-1:0];
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     if (q_cmd.order_qty == '0 || head_ff == NONE) begin
                        o_valid_in = 1'b1;
                        o_kind_in = K_NOFILL;
                        o_tk_in = q_cmd.order_id;
                        o_lf_in = q_cmd.order_qty;
                        o_cnt_in = 6'(cnt_ff);
                     end else begin
                        cur_in = head_ff[AW-1:0];
                        state_in = ST_RD;
                     end
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            prv_in = pv_rd;
            if (cmd_ff.op == OP_CANCEL) begin
               state_in = ST_OUT;
               used_in[cur_ff] = 1'b0;
               cnt_in = cnt_ff - 1'b1;
               if (pv_rd != NONE) begin
                  nx_we = 1'b1; nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
               end else begin
                  head_in = nx_rd;
               end
               if (nx_rd != NONE) begin
                  pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = pv_rd;
               end else begin
                  tail_in = pv_rd;
               end
               o_kind_in = K_CANCELLED;
               o_cnt_in = 6'(cnt_ff - 1'b1);
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_kind_in = K_TRADE;
               o_slot_in = 5'(cur_ff);
               o_mk_in = id_rd;
               o_tk_in = cmd_ff.order_id;
               o_fq_in = fill;
               o_pr_in = pr_rd;
               o_lf_in = left_ff - fill;
               left_in = left_ff - fill;
               ntr_in = ntr_ff + 1'b1;
               qty_we = 1'b1; qty_wd = mq_left;
               o_cnt_in = 6'(cnt_ff);
               o_last_in = 1'b1;
               state_in = ST_IDLE;
               if (mq_left == '0) begin
                  used_in[cur_ff] = 1'b0;
                  cnt_in = cnt_ff - 1'b1;
                  o_cnt_in = 6'(cnt_ff - 1'b1);
                  head_in = nx_rd;
                  if (nx_rd != NONE) begin
                     pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = NONE;
                  end else begin
                     tail_in = NONE;
                  end
                  if (left_ff != fill && nx_rd != NONE &&
                      ntr_ff != 6'(MAX_TRADES - 1)) begin
                     o_last_in = 1'b0;
                     cur_in = nx_rd[AW-1:0];
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_LINK: begin
            id_we = 1'b1; qty_we = 1'b1; pr_we = 1'b1; pv_we = 1'b1; nx_we = 1'b1;
            pv_wd = tail_ff; nx_wd = NONE;
            state_in = ST_OUT;
            used_in[cur_ff] = 1'b1;
            if (tail_ff == NONE) begin
               head_in = PW'(cur_ff);
            end
            tail_in = PW'(cur_ff);
            cnt_in = cnt_ff + 1'b1;
            o_kind_in = K_INSERTED;
            o_slot_in = 5'(cur_ff);
            o_cnt_in = 6'(cnt_ff + 1'b1);
         end
         ST_OUT: begin
            // second write port use: link old tail to new slot
            if (cmd_ff.op == OP_INSERT && prv_ff != NONE) begin
               nx_we = 1'b1; nx_wa = prv_ff[AW-1:0]; nx_wd = PW'(cur_ff);
            end
            o_valid_in = 1'b1;
            o_last_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_LINK) begin
         prv_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; left_ff <= left_in; cur_ff <= cur_in;
      prv_ff <= prv_in;
      o_kind_ff <= o_kind_in; o_slot_ff <= o_slot_in; o_mk_ff <= o_mk_in;
      o_tk_ff <= o_tk_in; o_fq_ff <= o_fq_in; o_pr_ff <= o_pr_in;
      o_lf_ff <= o_lf_in; o_cnt_ff <= o_cnt_in; o_last_ff <= o_last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         head_ff <= NONE;
         tail_ff <= NONE;
         cnt_ff <= '0;
         ntr_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
         ntr_ff <= ntr_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_maker_id = o_mk_ff;
   assign rsp_taker_id = o_tk_ff;
   assign rsp_fill_qty = o_fq_ff;
   assign rsp_trade_price = o_pr_ff;
   assign rsp_taker_left = o_lf_ff;
   assign rsp_orders_resting = o_cnt_ff;
   assign rsp_last = o_last_ff;

`ifndef NO_ASSERTIONS
   a_count: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) == $countones(used_ff)) else $error("count mismatch");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) == (head_ff == NONE)) else $error("head and count disagree");
   a_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NONE) == (tail_ff == NONE)) else $error("head and tail disagree");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == ST_IDLE) else $error("take while busy");
`endif
endmodule

// ----- hdl/price_level_fifo_matcher_unit.sv -----
// One price level of an order book with time priority. Items pass through a
// two entry queue into the back end. Insert goes via link and out, cancel
// via read, wait and out, each fill of a match via read, wait (registered
// slot read) and fill. Up to 32 trades per match, last marks the end.
module price_level_fifo_matcher_unit import plfm_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_order_qty,
   input  logic [31:0] req_order_price,
   input  logic [4:0]  req_cancel_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [4:0]  rsp_slot,
   output logic [31:0] rsp_maker_id,
   output logic [31:0] rsp_taker_id,
   output logic [31:0] rsp_fill_qty,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_taker_left,
   output logic [5:0]  rsp_orders_resting,
   output logic        rsp_last
);
   cmd_type in_cmd, q_cmd;
   logic q_valid, q_take;

   always_comb begin
      in_cmd.op = op_type'(req_op);
      in_cmd.order_id = req_order_id;
      in_cmd.order_qty = req_order_qty;
      in_cmd.order_price = req_order_price;
      in_cmd.cancel_slot = req_cancel_slot;
   end

   plfm_front u_front (.clock(clock), .reset(reset), .in_valid(req_valid),
      .in_stall(req_stall), .in_cmd(in_cmd), .q_valid(q_valid),
      .q_take(q_take), .q_cmd(q_cmd));

   plfm_back #(.SLOTS(SLOTS)) u_back (.clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_slot(rsp_slot), .rsp_maker_id(rsp_maker_id),
      .rsp_taker_id(rsp_taker_id), .rsp_fill_qty(rsp_fill_qty),
      .rsp_trade_price(rsp_trade_price), .rsp_taker_left(rsp_taker_left),
      .rsp_orders_resting(rsp_orders_resting), .rsp_last(rsp_last));
endmodule

// ----- dv/tb_top.sv -----
// testbench for the price level matcher: directed and random items checked against a local model
module tb_top;
   import plfm_pkg::*;

   localparam int NSLOT = 32;
   localparam int TRADE_CAP = 32;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  slot;
      logic [31:0] maker_id;
      logic [31:0] taker_id;
      logic [31:0] fill_qty;
      logic [31:0] trade_price;
      logic [31:0] taker_left;
      logic [5:0]  orders_resting;
      logic        last;
   } result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [31:0] req_order_id = '0;
   logic [31:0] req_order_qty = '0;
   logic [31:0] req_order_price = '0;
   logic [4:0]  req_cancel_slot = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_kind;
   logic [4:0]  rsp_slot;
   logic [31:0] rsp_maker_id, rsp_taker_id, rsp_fill_qty, rsp_trade_price, rsp_taker_left;
   logic [5:0]  rsp_orders_resting;
   logic        rsp_last;

   price_level_fifo_matcher_unit dut (.*);

   // book model
   logic        bk_used [NSLOT];
   logic [31:0] bk_id [NSLOT];
   logic [31:0] bk_qty [NSLOT];
   logic [31:0] bk_price [NSLOT];
   int          bk_prev [NSLOT];
   int          bk_next [NSLOT];
   int          bk_head, bk_tail, bk_count;

   result_type expected_fills[$];
   int      mismatches = 0;
   bit      quiet = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #50000000;
      $display("tb_top failed");
      $finish;
   end

   function automatic result_type mk(logic [2:0] k, logic [4:0] s, logic [31:0] m,
         logic [31:0] t, logic [31:0] f, logic [31:0] p, logic [31:0] l, logic la);
      result_type r;
      r.kind = k; r.slot = s; r.maker_id = m; r.taker_id = t; r.fill_qty = f;
      r.trade_price = p; r.taker_left = l; r.orders_resting = bk_count[5:0]; r.last = la;
      return r;
   endfunction

   function automatic void queue_result(result_type r);
      expected_fills.insert(expected_fills.size(), r);
   endfunction

   function automatic void unlink(int s);
      int p, n;
      p = bk_prev[s];
      n = bk_next[s];
      if (p < NSLOT) bk_next[p] = n; else bk_head = n;
      if (n < NSLOT) bk_prev[n] = p; else bk_tail = p;
      bk_used[s] = 0;
      if (bk_count > 0) bk_count--;
   endfunction

   function automatic void predict_book(logic [1:0] op, logic [31:0] id, logic [31:0] qty,
         logic [31:0] price, logic [4:0] cs);
      int s, h, k;
      logic [31:0] left, fill, mk_id, mk_pr;
      if (op == OP_INSERT) begin
         for (s = 0; s < NSLOT; s++) if (!bk_used[s]) break;
         if (s >= NSLOT) begin
            queue_result(mk(K_FULL, 0, 0, 0, 0, 0, 0, 1));
            return;
         end
         bk_used[s] = 1; bk_id[s] = id; bk_qty[s] = qty; bk_price[s] = price;
         bk_prev[s] = bk_tail; bk_next[s] = NSLOT;
         if (bk_tail < NSLOT) bk_next[bk_tail] = s; else bk_head = s;
         bk_tail = s;
         bk_count++;
         queue_result(mk(K_INSERTED, s[4:0], 0, 0, 0, 0, 0, 1));
      end else if (op == OP_CANCEL) begin
         if (!bk_used[cs]) begin
            queue_result(mk(K_BADSLOT, cs, 0, 0, 0, 0, 0, 1));
            return;
         end
         unlink(cs);
         queue_result(mk(K_CANCELLED, cs, 0, 0, 0, 0, 0, 1));
      end else begin
         left = qty;
         k = 0;
         while (left != 0 && bk_head < NSLOT && k < TRADE_CAP) begin
            h = bk_head;
            fill = (left < bk_qty[h]) ? left : bk_qty[h];
            mk_id = bk_id[h];
            mk_pr = bk_price[h];
            left -= fill;
            bk_qty[h] -= fill;
            if (bk_qty[h] == 0) unlink(h);
            queue_result(mk(K_TRADE, h[4:0], mk_id, id, fill, mk_pr, left, 0));
            k++;
         end
         if (k == 0) queue_result(mk(K_NOFILL, 0, 0, id, 0, 0, qty, 1));
         else expected_fills[$].last = 1;
      end
   endfunction

   task automatic send_item(logic [1:0] op, logic [31:0] id, logic [31:0] qty,
         logic [31:0] price, logic [4:0] cs);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_op <= op; req_order_id <= id; req_order_qty <= qty;
      req_order_price <= price; req_cancel_slot <= cs;
      do @(posedge clock); while (req_stall);
      predict_book(op, id, qty, price, cs);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_fills.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_slot, rsp_maker_id, rsp_taker_id, rsp_fill_qty,
                rsp_trade_price, rsp_taker_left, rsp_orders_resting, rsp_last};
         if (expected_fills.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_fills.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
            end
         end
      end
   end

   // receiver stall bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   task automatic test_directed;
      send_item(OP_MATCH, 32'h1, 32'd5, 0, 0);
      send_item(OP_CANCEL, 0, 0, 0, 5'd0);
      send_item(OP_CANCEL, 0, 0, 0, 5'd31);
      send_item(OP_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 5'd31);
      send_item(OP_INSERT, 32'h0, 32'h0, 32'h0, 5'd0);
      send_item(OP_INSERT, 32'h55, 32'd10, 32'd7, 0);
      send_item(OP_MATCH, 32'h77, 32'd0, 0, 0);
      send_item(OP_OTHER, 32'h88, 32'd3, 0, 0);
      send_item(OP_CANCEL, 0, 0, 0, 5'd2);
      send_item(OP_MATCH, 32'hffffffff, 32'hffffffff, 0, 0);
      send_item(OP_MATCH, 32'h99, 32'd4, 0, 0);
   endtask

   task automatic test_full_store;
      int i;
      for (i = 0; i < NSLOT + 1; i++)
         send_item(OP_INSERT, $urandom, $urandom_range(0, 3), $urandom, 0);
      send_item(OP_CANCEL, 0, 0, 0, 5'd17);
      send_item(OP_MATCH, 32'h123, 32'hffffffff, 0, 0);
   endtask

   task automatic test_trade_cap;
      int i;
      for (i = 0; i < NSLOT; i++) send_item(OP_INSERT, i, 1, i * 3, 0);
      send_item(OP_MATCH, 32'habc, 32'd100, 0, 0);
      send_item(OP_MATCH, 32'habd, 32'd1, 0, 0);
   endtask

   task automatic test_random(int n);
      int i, r;
      logic [31:0] q;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         q = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20);
         if (r < 5)
            send_item(OP_INSERT, $urandom, q, $urandom, 5'($urandom));
         else if (r < 7)
            send_item(OP_CANCEL, $urandom, $urandom, $urandom, 5'($urandom_range(0, 31)));
         else
            send_item(r == 9 && $urandom_range(0, 2) == 0 ? OP_OTHER : OP_MATCH,
                      $urandom, q, $urandom, 5'($urandom));
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < NSLOT; i++) begin
         bk_used[i] = 0; bk_id[i] = 0; bk_qty[i] = 0; bk_price[i] = 0;
         bk_prev[i] = 0; bk_next[i] = 0;
      end
      bk_head = NSLOT; bk_tail = NSLOT; bk_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_full_store();
      test_trade_cap();
      test_random(50);
      quiet = 1;
      test_random(20);
      drain();
      if (mismatches == 0 && expected_fills.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
